/* src/tle_pkg.sv */
// Shared types, constants and helpers for the terminal line editor.
package tle_pkg;

    // Line buffer size; one slot stays free, so at most capacity - 1 characters are held
    localparam int BUFFER_CAPACITY = 64;
    localparam int CNT_W           = $clog2(BUFFER_CAPACITY);
    localparam int COL_W           = 7;
    localparam int LEN_W           = 6;
    localparam int SECS_W          = 19;
    localparam int STEP_W          = 5;

    // Work queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Input commands
    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_CLOCK = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_TERM   = 2'd0;
    localparam logic [1:0] KIND_RETURN = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    // Terminal characters
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_H        = 8'h48;
    localparam logic [7:0] CH_K        = 8'h4B;
    localparam logic [7:0] CH_G        = 8'h47;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_ONE      = 8'h31;
    localparam logic [7:0] CH_TWO      = 8'h32;
    localparam logic [7:0] CH_THREE    = 8'h33;
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_PRINT_LO = 8'h20;
    localparam logic [7:0] CH_PRINT_HI = 8'h7E;
    localparam logic [3:0] ASCII_DIGIT = 4'h3;

    // Clock display: 99:59:59 limit and reciprocals for exact division by 60
    localparam logic [SECS_W-1:0] MAX_SECONDS = 19'd359999;
    localparam logic [19:0]       SEC_RECIP   = 20'd559241;
    localparam int                SEC_SHIFT   = 25;
    localparam logic [13:0]       MIN_RECIP   = 14'd8739;
    localparam int                MIN_SHIFT   = 19;

    // Work classes handed from front to back
    typedef enum logic [2:0] {
        OP_ECHO,
        OP_BS,
        OP_RET,
        OP_CLOCK,
        OP_CLEAR,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [7:0]        data;
        logic [SECS_W-1:0] secs;
        logic [COL_W-1:0]  col;
        logic [LEN_W-1:0]  length;
        logic              ovf;
    } t_entry;

    // Split a value below 100 into tens and ones digits
    function automatic logic [7:0] to_digits(input logic [6:0] v);
        logic [3:0] tens;
        logic [6:0] ones;
        tens = 4'd0;
        ones = v;
        for (int k = 1; k < 10; k++) begin
            if (v >= 7'(10 * k)) begin
                tens = 4'(k);
                ones = v - 7'(10 * k);
            end
        end
        return {tens, ones[3:0]};
    endfunction

endpackage

/* src/tle_front.sv */
// Front end: accepts words, updates the line buffer and count, classifies the work.
module tle_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_command,
    input  logic [7:0]                    i_data_byte,
    input  logic [tle_pkg::SECS_W-1:0]    i_elapsed_seconds,
    input  logic [5:0]                    i_read_index,
    output logic                          o_push,
    output tle_pkg::t_entry               o_entry,
    input  logic                          i_full
);

    logic [tle_pkg::CNT_W-1:0] r_count;
    logic [tle_pkg::CNT_W-1:0] n_count;
    logic [7:0]                r_line [tle_pkg::BUFFER_CAPACITY];
    logic [7:0]                r_rd_data;
    tle_pkg::t_entry           r_b;
    tle_pkg::t_entry           n_b;
    logic                      r_b_valid;
    logic                      r_b_hit;
    logic                      accept;
    logic                      wr_en;
    logic                      rd_en;
    logic                      printable;
    logic                      full_line;
    logic                      hit;
    logic [tle_pkg::SECS_W-1:0] secs_sat;

    assign o_push     = r_b_valid && !i_full;
    assign o_in_ready = !r_b_valid || !i_full;
    assign accept     = i_in_valid && o_in_ready;

    assign printable = (i_data_byte >= tle_pkg::CH_PRINT_LO) &&
                       (i_data_byte <= tle_pkg::CH_PRINT_HI);
    assign full_line = (r_count == tle_pkg::CNT_W'(tle_pkg::BUFFER_CAPACITY - 1));
    assign hit       = (8'(i_read_index) < 8'(r_count));
    assign secs_sat  = (i_elapsed_seconds > tle_pkg::MAX_SECONDS) ?
                       tle_pkg::MAX_SECONDS : i_elapsed_seconds;

    // Classify the incoming word and work out the new count
    always_comb begin
        n_count     = r_count;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        n_b.op      = tle_pkg::OP_RET;
        n_b.data    = i_data_byte;
        n_b.secs    = secs_sat;
        n_b.col     = tle_pkg::COL_W'(r_count) + tle_pkg::COL_W'(1);
        n_b.ovf     = 1'b0;
        unique case (i_command)
            tle_pkg::CMD_BYTE: begin
                if (printable) begin
                    if (!full_line) begin
                        n_b.op  = tle_pkg::OP_ECHO;
                        n_count = r_count + tle_pkg::CNT_W'(1);
                        wr_en   = 1'b1;
                    end else begin
                        n_b.ovf = 1'b1;
                    end
                end else if (i_data_byte == tle_pkg::CH_BS && r_count != '0) begin
                    n_b.op  = tle_pkg::OP_BS;
                    n_count = r_count - tle_pkg::CNT_W'(1);
                end
            end
            tle_pkg::CMD_CLOCK: begin
                n_b.op = tle_pkg::OP_CLOCK;
            end
            tle_pkg::CMD_CLEAR: begin
                n_b.op  = tle_pkg::OP_CLEAR;
                n_count = '0;
            end
            default: begin
                n_b.op   = tle_pkg::OP_READ;
                n_b.data = 8'h00;
                rd_en    = 1'b1;
            end
        endcase
        n_b.length = tle_pkg::LEN_W'(n_count);
    end

    // Hold the count and the stage valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_b_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count   <= n_count;
                r_b_valid <= 1'b1;
            end else if (o_push) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    // Capture the classified word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b     <= n_b;
            r_b_hit <= hit;
        end
    end

    // Line buffer: write on append, registered read for buffer reads
    always_ff @(posedge i_clk) begin
        if (accept && wr_en) begin
            r_line[r_count] <= i_data_byte;
        end
        if (accept && rd_en) begin
            r_rd_data <= r_line[tle_pkg::CNT_W'(i_read_index)];
        end
    end

    // Merge read data into the queued word
    always_comb begin
        o_entry = r_b;
        if (r_b.op == tle_pkg::OP_READ && r_b_hit) begin
            o_entry.data = r_rd_data;
        end
    end

endmodule

/* src/tle_queue.sv */
// Short work queue that decouples the front end from the output sequencer.
module tle_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tle_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output tle_pkg::t_entry o_head
);

    tle_pkg::t_entry             r_slot [tle_pkg::QUEUE_DEPTH];
    logic [tle_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [tle_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [tle_pkg::QPTR_W:0]    r_fill;

    assign o_full  = (r_fill == (tle_pkg::QPTR_W + 1)'(tle_pkg::QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_head  = r_slot[r_rd_ptr];

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + tle_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + tle_pkg::QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + (tle_pkg::QPTR_W + 1)'(1);
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - (tle_pkg::QPTR_W + 1)'(1);
            end
        end
    end

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

endmodule

/* src/tle_back.sv */
// Back end: expands each queued word into terminal bytes, one per cycle while the consumer accepts them.
module tle_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_empty,
    input  tle_pkg::t_entry           i_head,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [1:0]                o_kind,
    output logic [7:0]                o_out_byte,
    output logic [tle_pkg::LEN_W-1:0] o_line_length,
    output logic                      o_overflow,
    output logic                      o_last
);

    tle_pkg::t_entry            r_cur;
    logic                       r_cur_valid;
    logic [tle_pkg::STEP_W-1:0] r_step;
    logic                       r_out_valid;
    logic [1:0]                 r_out_kind;
    logic [7:0]                 r_out_byte;
    logic [tle_pkg::LEN_W-1:0]  r_out_len;
    logic                       r_out_ovf;
    logic                       r_out_last;

    // Clock digit pipeline
    logic [12:0]                r_mtot;
    logic [6:0]                 r_hours;
    logic [5:0]                 r_sec;
    logic [5:0]                 r_min;
    logic [38:0]                sec_prod;
    logic [26:0]                min_prod;

    logic                       out_free;
    logic                       advance;
    logic [1:0]                 e_kind;
    logic [7:0]                 e_byte;
    logic                       e_ovf;
    logic                       e_last;
    logic [7:0]                 hd;
    logic [7:0]                 md;
    logic [7:0]                 sd;
    logic [7:0]                 cd;

    assign out_free = !r_out_valid || i_out_ready;
    assign advance  = r_cur_valid && out_free;
    assign o_pop    = !i_empty && (!r_cur_valid || (advance && e_last));

    // Split seconds into h/m/s over three registered steps
    assign sec_prod = 39'(r_cur.secs) * 39'(tle_pkg::SEC_RECIP);
    assign min_prod = 27'(r_mtot) * 27'(tle_pkg::MIN_RECIP);

    always_ff @(posedge i_clk) begin
        r_mtot  <= 13'(sec_prod >> tle_pkg::SEC_SHIFT);
        r_hours <= 7'(min_prod >> tle_pkg::MIN_SHIFT);
        r_sec   <= 6'(r_cur.secs - ((19'(r_mtot) << 6) - (19'(r_mtot) << 2)));
        r_min   <= 6'(r_mtot - ((13'(r_hours) << 6) - (13'(r_hours) << 2)));
    end

    assign hd = tle_pkg::to_digits(r_hours);
    assign md = tle_pkg::to_digits(7'(r_min));
    assign sd = tle_pkg::to_digits(7'(r_sec));
    assign cd = tle_pkg::to_digits(r_cur.col);

    // Pick the byte for the current step
    always_comb begin
        e_kind = tle_pkg::KIND_TERM;
        e_byte = 8'h00;
        e_ovf  = 1'b0;
        e_last = 1'b0;
        unique case (r_cur.op)
            tle_pkg::OP_ECHO: begin
                if (r_step == '0) begin
                    e_byte = r_cur.data;
                end else begin
                    e_kind = tle_pkg::KIND_RETURN;
                    e_byte = r_cur.data;
                    e_last = 1'b1;
                end
            end
            tle_pkg::OP_BS: begin
                case (r_step)
                    5'd0:    e_byte = tle_pkg::CH_BS;
                    5'd1:    e_byte = tle_pkg::CH_SPACE;
                    5'd2:    e_byte = tle_pkg::CH_BS;
                    default: begin
                        e_kind = tle_pkg::KIND_RETURN;
                        e_byte = r_cur.data;
                        e_last = 1'b1;
                    end
                endcase
            end
            tle_pkg::OP_RET: begin
                e_kind = tle_pkg::KIND_RETURN;
                e_byte = r_cur.data;
                e_ovf  = r_cur.ovf;
                e_last = 1'b1;
            end
            tle_pkg::OP_READ: begin
                e_kind = tle_pkg::KIND_READ;
                e_byte = r_cur.data;
                e_last = 1'b1;
            end
            tle_pkg::OP_CLEAR: begin
                case (r_step)
                    5'd0:    e_byte = tle_pkg::CH_ESC;
                    5'd1:    e_byte = tle_pkg::CH_LBRACKET;
                    5'd2:    e_byte = tle_pkg::CH_TWO;
                    5'd3:    e_byte = tle_pkg::CH_K;
                    5'd4:    e_byte = tle_pkg::CH_ESC;
                    5'd5:    e_byte = tle_pkg::CH_LBRACKET;
                    5'd6:    e_byte = tle_pkg::CH_ONE;
                    default: begin
                        e_byte = tle_pkg::CH_G;
                        e_last = 1'b1;
                    end
                endcase
            end
            default: begin
                case (r_step)
                    5'd0:    e_byte = tle_pkg::CH_ESC;
                    5'd1:    e_byte = tle_pkg::CH_LBRACKET;
                    5'd2:    e_byte = tle_pkg::CH_H;
                    5'd3:    e_byte = {tle_pkg::ASCII_DIGIT, hd[7:4]};
                    5'd4:    e_byte = {tle_pkg::ASCII_DIGIT, hd[3:0]};
                    5'd5:    e_byte = tle_pkg::CH_COLON;
                    5'd6:    e_byte = {tle_pkg::ASCII_DIGIT, md[7:4]};
                    5'd7:    e_byte = {tle_pkg::ASCII_DIGIT, md[3:0]};
                    5'd8:    e_byte = tle_pkg::CH_COLON;
                    5'd9:    e_byte = {tle_pkg::ASCII_DIGIT, sd[7:4]};
                    5'd10:   e_byte = {tle_pkg::ASCII_DIGIT, sd[3:0]};
                    5'd11:   e_byte = tle_pkg::CH_ESC;
                    5'd12:   e_byte = tle_pkg::CH_LBRACKET;
                    5'd13:   e_byte = tle_pkg::CH_THREE;
                    5'd14:   e_byte = tle_pkg::CH_SEMI;
                    5'd15:   e_byte = {tle_pkg::ASCII_DIGIT, cd[7:4]};
                    5'd16:   e_byte = {tle_pkg::ASCII_DIGIT, cd[3:0]};
                    default: begin
                        e_byte = tle_pkg::CH_H;
                        e_last = 1'b1;
                    end
                endcase
            end
        endcase
    end

    // Sequence the current word and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cur_valid <= 1'b1;
                r_step      <= '0;
            end else if (advance && e_last) begin
                r_cur_valid <= 1'b0;
            end else if (advance) begin
                r_step <= r_step + tle_pkg::STEP_W'(1);
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the next word and the emitted result
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_head;
        end
        if (advance) begin
            r_out_kind <= e_kind;
            r_out_byte <= e_byte;
            r_out_len  <= r_cur.length;
            r_out_ovf  <= e_ovf;
            r_out_last <= e_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_out_byte    = r_out_byte;
    assign o_line_length = r_out_len;
    assign o_overflow    = r_out_ovf;
    assign o_last        = r_out_last;

endmodule

/* src/terminal_line_editor_echo_top.sv */
// Terminal line editor top level: front end, work queue and output sequencer.
// A word's first result passes the front-end register, a queue slot, the sequencer's
// current-word register and its single output register. Results leave one per cycle
// while the consumer takes them; a word has 1 to 18 results (a clock word 18).
// Input words are taken every cycle while the four-entry work queue has room.
// Reset clears the line count and the work queue; the line buffer is not cleared.
module terminal_line_editor_echo_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_data_byte,
    input  logic [18:0] i_elapsed_seconds,
    input  logic [5:0]  i_read_index,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic [5:0]  o_line_length,
    output logic        o_overflow,
    output logic        o_last
);

    tle_pkg::t_entry push_entry;
    tle_pkg::t_entry head_entry;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;

    // Accept and classify
    tle_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_command         (i_command),
        .i_data_byte       (i_data_byte),
        .i_elapsed_seconds (i_elapsed_seconds),
        .i_read_index      (i_read_index),
        .o_push            (push),
        .o_entry           (push_entry),
        .i_full            (q_full)
    );

    // Buffer classified words
    tle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (head_entry)
    );

    // Emit terminal bytes
    tle_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (q_empty),
        .i_head        (head_entry),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_out_byte    (o_out_byte),
        .o_line_length (o_line_length),
        .o_overflow    (o_overflow),
        .o_last        (o_last)
    );

endmodule
